[rtl/core/bol_pkg.sv]
// ----------------------------------------------------------------------------
// bol_pkg
// shared opcodes, status codes and field widths of the bounded ordered list
// ----------------------------------------------------------------------------
package bol_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 8;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;

  typedef logic [OP_W-1:0]   opcode_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam opcode_t OP_PUSH_FRONT = 3'd0;
  localparam opcode_t OP_PUSH_BACK  = 3'd1;
  localparam opcode_t OP_POP_FRONT  = 3'd2;
  localparam opcode_t OP_POP_BACK   = 3'd3;
  localparam opcode_t OP_DELETE_AT  = 3'd4;
  localparam opcode_t OP_DUMP       = 3'd5;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_OOB   = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

endpackage

[rtl/core/bol_ring_add.sv]
// ----------------------------------------------------------------------------
// bol_ring_add
// shared ring index adder: (base + offset) wrapped into 0 .. CAPACITY-1
// ----------------------------------------------------------------------------
module bol_ring_add #(
  parameter int CAPACITY = 16,
  parameter int AW       = $clog2(CAPACITY)
) (
  input  logic [AW-1:0] base,
  input  logic [AW-1:0] offset,
  output logic [AW-1:0] sum
);

  logic [AW:0] raw;

  // both operands below capacity, so one compare and subtract is enough
  always_comb begin
    raw = {1'b0, base} + {1'b0, offset};
    if (raw >= (AW+1)'(CAPACITY)) begin
      raw = raw - (AW+1)'(CAPACITY);
    end
    sum = raw[AW-1:0];
  end

endmodule

[rtl/core/bounded_ordered_list.sv]
// ----------------------------------------------------------------------------
// bounded_ordered_list
// ordered list of signed 32-bit values held in a ring buffer with a sequencer
// ----------------------------------------------------------------------------
// push front/back, pop front/back, deleting the back element, faults and unknown
//   opcodes give their result in the output register the cycle after the input transfer
// delete at position p of n elements, p not the back: the elements behind p are
//   shifted forward, one read/write pair each, through the single ram port pair
// dump of n elements: each element is read from the ram, then presented, plus stalls
// throughput: one request at a time; in_ready is low while the sequencer works
// reset: pointers, count, sequencer and output valid cleared; the element ram
//   is not cleared, entries are only read after being written
module bounded_ordered_list
  import bol_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          in_opcode,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [POS_W-1:0]         in_position,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [DATA_W-1:0] out_element,
  output logic [CW-1:0]            out_count,
  output logic                     out_last
);

  // width wide enough to compare a position against the count
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SH_RD  = 5'b00010,
    S_SH_WR  = 5'b00100,
    S_DP_RD  = 5'b01000,
    S_DP_OUT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // ring buffer bookkeeping: head is the physical slot of the front element
  logic [AW-1:0] head_r,  head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r,   idx_nxt;    // logical index walked by shift and dump

  // element ram, one write and one registered read port
  logic [DATA_W-1:0] mem_r [CAPACITY];
  logic [DATA_W-1:0] rd_data_r;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data;

  // shared ring adder
  logic [AW-1:0] offs;
  logic [AW-1:0] slot;

  // output register
  logic              out_valid_r;
  status_t           out_status_r;
  logic [DATA_W-1:0] out_element_r;
  logic [CW-1:0]     out_count_r;
  logic              out_last_r;

  logic              out_load;
  status_t           ld_status;
  logic [DATA_W-1:0] ld_element;
  logic              ld_last;

  logic              in_xfer;
  logic              full, empty;
  logic [CMPW-1:0]   pos_ext, cnt_ext;

  bol_ring_add #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ring_add (
    .base   (head_r),
    .offset (offs),
    .sum    (slot)
  );

  // a new request may enter while the previous result leaves
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_xfer  = in_valid && in_ready;

  assign full    = (count_r == CW'(CAPACITY));
  assign empty   = (count_r == '0);
  assign pos_ext = CMPW'(in_position);
  assign cnt_ext = CMPW'(count_r);

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    offs       = '0;
    wr_en      = 1'b0;
    wr_addr    = slot;
    wr_data    = in_value;
    rd_en      = 1'b0;
    rd_addr    = slot;
    out_load   = 1'b0;
    ld_status  = ST_OK;
    ld_element = '0;
    ld_last    = 1'b1;

    case (state_r)
      S_IDLE: begin
        // adder offset chosen from the opcode alone
        case (in_opcode)
          OP_PUSH_FRONT: offs = AW'(CAPACITY - 1);   // head - 1
          OP_PUSH_BACK:  offs = AW'(count_r);        // slot after the back
          OP_POP_FRONT:  offs = AW'(1);              // head + 1
          default:       offs = '0;
        endcase

        if (in_xfer) begin
          case (in_opcode)
            OP_PUSH_FRONT: begin
              out_load = 1'b1;
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                head_nxt  = slot;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_PUSH_BACK: begin
              out_load = 1'b1;
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_POP_FRONT: begin
              out_load = 1'b1;
              if (empty) begin
                ld_status = ST_EMPTY;
              end else begin
                head_nxt  = slot;
                count_nxt = count_r - CW'(1);
              end
            end
            OP_POP_BACK: begin
              out_load = 1'b1;
              if (empty) begin
                ld_status = ST_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            OP_DELETE_AT: begin
              if (empty) begin
                out_load  = 1'b1;
                ld_status = ST_EMPTY;
              end else if (pos_ext >= cnt_ext) begin
                out_load  = 1'b1;
                ld_status = ST_OOB;
              end else if (pos_ext + CMPW'(1) == cnt_ext) begin
                // deleting the back element needs no shifting
                out_load  = 1'b1;
                count_nxt = count_r - CW'(1);
              end else begin
                // close the gap one element per read/write pair
                idx_nxt   = AW'(in_position);
                state_nxt = S_SH_RD;
              end
            end
            OP_DUMP: begin
              if (empty) begin
                out_load  = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_DP_RD;
              end
            end
            default: begin
              // unused opcodes leave the list as it is
              out_load = 1'b1;
            end
          endcase
        end
      end

      S_SH_RD: begin
        offs      = idx_r + AW'(1);
        rd_en     = 1'b1;
        state_nxt = S_SH_WR;
      end

      S_SH_WR: begin
        offs    = idx_r;
        wr_en   = 1'b1;
        wr_data = rd_data_r;
        if (CW'(idx_r) + CW'(2) == count_r) begin
          // moved the back element, list is one shorter
          count_nxt = count_r - CW'(1);
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_SH_RD;
        end
      end

      S_DP_RD: begin
        offs      = idx_r;
        rd_en     = 1'b1;
        state_nxt = S_DP_OUT;
      end

      S_DP_OUT: begin
        // hold the read data until the output register is free
        if (!out_valid_r || out_ready) begin
          out_load   = 1'b1;
          ld_element = rd_data_r;
          ld_last    = (CW'(idx_r) + CW'(1) == count_r);
          if (ld_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_DP_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, count reported after the operation
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r  <= ld_status;
      out_element_r <= ld_element;
      out_count_r   <= count_nxt;
      out_last_r    <= ld_last;
    end
  end

  // element ram
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_count   = out_count_r;
  assign out_last    = out_last_r;

endmodule

[rtl/core/bol_checker.sv]
// ----------------------------------------------------------------------------
// bol_checker
// port level checks of the bounded ordered list, bound to the top level
// ----------------------------------------------------------------------------
module bol_checker
  import bol_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [STAT_W-1:0]        out_status,
  input logic signed [DATA_W-1:0] out_element,
  input logic [CW-1:0]            out_count,
  input logic                     out_last
);

  // a stalled result holds its element and last flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_element) && $stable(out_last))
    else $error("result changed while stalled");

  // no new request while an untaken result would be overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("request taken while result pending");

  // faults always end a request and carry a zero element
  a_fault_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last && out_element == '0)
    else $error("fault result not final");

  // empty reported only with no elements, count within capacity
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= CW'(CAPACITY) &&
                  (out_status != ST_EMPTY || out_count == '0))
    else $error("bad count in result");

endmodule

bind bounded_ordered_list bol_checker #(
  .CAPACITY (CAPACITY),
  .CW       (CW)
) u_bol_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_status  (out_status),
  .out_element (out_element),
  .out_count   (out_count),
  .out_last    (out_last)
);
